// ===== hw/rtl/rsma_pkg.sv =====
// Package for the running-sum moving average core.
// Holds field widths, reset values and the command and status structs
// that pass between the controller and the datapath. No dependencies.
package rsma_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int WIN_CFG_W       = 7;
  localparam int DEF_RING_DEPTH  = 64;
  localparam logic [WIN_CFG_W-1:0] WIN_RESET = 7'd8;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic mod_step;
    logic rd_en;
    logic update;
    logic div_step;
    logic out_load;
  } rsma_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic wrap;
    logic filled;
    logic div_last;
  } rsma_sts_t;

endpackage

// ===== hw/rtl/rsma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the sample ring of the moving average core.
module rsma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rsma_datapath.sv =====
// Datapath of the moving average core: window register, sample ring,
// running sum, write position, bit-serial divider and output register.
// Depends on rsma_pkg and rsma_ram.
module rsma_datapath
  import rsma_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [WIN_CFG_W-1:0] cfg_wr_data,
  input  logic [SAMPLE_W-1:0]  in_tdata,
  input  rsma_cmd_t            cmd,
  output rsma_sts_t            sts,
  output logic [SAMPLE_W-1:0]  out_tdata
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int EW    = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int CW    = $clog2(SUM_W);

  logic [WIN_CFG_W-1:0] window_length_r;
  logic [EW-1:0]        win_eff;
  logic [AW-1:0]        clr_addr_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [EW-1:0]        wp_r;
  logic                 filled_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_nxt;
  logic [SUM_W-1:0]     quo_r;
  logic [EW-1:0]        rem_r;
  logic [CW-1:0]        div_cnt_r;
  logic [SAMPLE_W-1:0]  out_data_r;
  logic [SAMPLE_W-1:0]  ring_rdata;
  logic [AW-1:0]        slot;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic [EW:0]          rem_sh;
  logic [EW:0]          rem_sub;
  logic                 rem_ge;
  logic [SAMPLE_W-1:0]  quo_sat;

  always_comb begin
    if (window_length_r == '0) begin
      win_eff = EW'(1);
    end else if (int'(window_length_r) > RING_DEPTH) begin
      win_eff = EW'(RING_DEPTH);
    end else begin
      win_eff = EW'(window_length_r);
    end
  end

  assign slot    = wp_r[AW-1:0];
  assign sum_nxt = sum_r + SUM_W'(sample_r) - SUM_W'(ring_rdata);

  assign ram_we    = cmd.clear_step | cmd.update;
  assign ram_waddr = cmd.clear_step ? clr_addr_r : slot;
  assign ram_wdata = cmd.clear_step ? '0 : sample_r;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, win_eff};
  assign rem_ge  = rem_sh >= {1'b0, win_eff};
  assign quo_sat = (|quo_r[SUM_W-1:SAMPLE_W]) ? '1 : quo_r[SAMPLE_W-1:0];

  rsma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(slot),
    .rdata(ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WIN_RESET;
      clr_addr_r      <= '0;
      wp_r            <= '0;
      filled_r        <= 1'b0;
      sum_r           <= '0;
      div_cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_length_r <= cfg_wr_data;
      end
      if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.accept && (wp_r == win_eff)) begin
        filled_r <= 1'b1;
      end
      if (cmd.mod_step) begin
        wp_r <= wp_r - win_eff;
      end
      if (cmd.update) begin
        wp_r      <= wp_r + EW'(1);
        sum_r     <= sum_nxt;
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_tdata;
    end
    if (cmd.update) begin
      quo_r <= sum_nxt;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[EW-1:0] : rem_sh[EW-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= filled_r ? quo_sat : sample_r;
    end
  end

  assign sts.clear_last = (clr_addr_r == AW'(RING_DEPTH - 1));
  assign sts.wrap       = (wp_r >= win_eff);
  assign sts.filled     = filled_r;
  assign sts.div_last   = (div_cnt_r == CW'(SUM_W - 1));
  assign out_tdata      = out_data_r;

endmodule

// ===== hw/rtl/rsma_ctrl.sv =====
// Controller state machine of the moving average core.
// Sequences ring clearing, slot selection, update, division and output.
// Depends on rsma_pkg.
module rsma_ctrl
  import rsma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  rsma_sts_t sts,
  output rsma_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.accept     = (state_r == S_IDLE) && in_tvalid && in_tready_r;
    cmd.mod_step   = (state_r == S_WRAP) && sts.wrap;
    cmd.rd_en      = (state_r == S_WRAP) && !sts.wrap;
    cmd.update     = (state_r == S_UPDATE);
    cmd.div_step   = (state_r == S_DIV);
    cmd.out_load   = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (sts.clear_last) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.accept) begin
            state_r     <= S_WRAP;
            in_tready_r <= 1'b0;
          end
        end
        S_WRAP: begin
          if (!sts.wrap) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_r <= sts.filled ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (sts.div_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> (state_r == S_IDLE))
    else $error("Request ready outside the idle state.");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("Result register loaded while a result still waits.");

  a_div_only_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> sts.filled)
    else $error("Division started before the window has filled.");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready_r)
    else $error("Ready still high after a request was taken.");
`endif

endmodule

// ===== hw/rtl/running_sum_moving_average_core.sv =====
// Running-sum moving average: each accepted sample replaces the oldest entry of
// a ring in RAM, the running sum is adjusted by new minus old, and the result is
// the raw sample until the window has filled once, then the truncated mean. After
// reset the ring is cleared one entry per cycle, with in_tready low. Once the
// window is full, each item's sum goes through the bit-serial restoring divider,
// which produces one quotient bit per cycle; during warm-up the division is
// skipped. An item that finds the write position at or above the window first
// reduces the position by the window length, one step at a time, until it lies
// below: once for the item that starts each new lap of the window, and more
// often for the first item after the window is shrunk. A finished result waits
// in an output register.
module running_sum_moving_average_core
  import rsma_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [WIN_CFG_W-1:0] cfg_wr_data,   // window_length
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMPLE_W-1:0]  in_tdata,      // sample
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata      // filtered
);

  rsma_cmd_t cmd;
  rsma_sts_t sts;

  rsma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsma_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tdata  (out_tdata)
  );

endmodule
